// ----- src/doubly_linked_list_manager_assert.svh -----
// Assertion macros for the linked list manager.
// Included by modules that check their own sequencing.
`ifndef DOUBLY_LINKED_LIST_MANAGER_ASSERT_SVH
`define DOUBLY_LINKED_LIST_MANAGER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define DLL_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define DLL_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- src/dll_pkg.sv -----
// Package for the linked list manager: sizes and request codes.
// No dependencies.
package dll_pkg;
  localparam int NodeCount = 16;
  localparam int ListCount = 4;
  localparam int ItemWidth = 16;
  localparam int Entries = NodeCount + ListCount;
  localparam int PtrW = $clog2(Entries);
  localparam int NodeW = $clog2(NodeCount);
  localparam int CntW = $clog2(NodeCount + 1);
  localparam int OwnW = $clog2(ListCount + 1);

  localparam logic [3:0] ReqClear  = 4'd0;
  localparam logic [3:0] ReqBind   = 4'd1;
  localparam logic [3:0] ReqTail   = 4'd2;
  localparam logic [3:0] ReqHead   = 4'd3;
  localparam logic [3:0] ReqGet    = 4'd4;
  localparam logic [3:0] ReqRotate = 4'd5;
  localparam logic [3:0] ReqInsert = 4'd6;
  localparam logic [3:0] ReqRemove = 4'd7;
  localparam logic [3:0] ReqPeek   = 4'd8;
  localparam logic [3:0] ReqPrev   = 4'd9;
  localparam logic [3:0] ReqNext   = 4'd10;

  typedef logic [PtrW-1:0] ptr_t;
endpackage

// ----- src/doubly_linked_list_manager.sv -----
// Linked list manager: several circular doubly linked lists over one node pool.
// Uses dll_pkg and the assertion macro header.
//
// Usage: a request transaction (req_type, list_id, node_id, ref_node, item_value)
// is taken on in_valid/in_ready; exactly one result transaction (item_out,
// item_valid, count_out, status) follows on out_valid/out_ready.
// The pointer tables are held in registers and changed by a small sequencer
// that performs one pointer write per cycle through a single shared link unit.
// After acceptance a request is decided; a rejected request goes straight to
// the result, others pass through the link step, which does no pointer write for
// a peek, prev or next, two for a get or remove, four for a put or insert and six
// for a rotate on a list with two or more members. A clear instead sweeps the
// node owner table, one node per cycle. The next request is taken at the earliest
// in the cycle the result is collected. in_ready is high whenever the sequencer is
// idle and the output register is free or being emptied. At reset every sentinel
// links to itself, all nodes are detached and all counts are zero; no result is
// pending. When the receiver stalls the result is held in the output register and
// no further request is taken until it has been collected.
`include "doubly_linked_list_manager_assert.svh"
module doubly_linked_list_manager (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  req_type,
  input  logic [1:0]  list_id,
  input  logic [3:0]  node_id,
  input  logic [3:0]  ref_node,
  input  logic [15:0] item_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] item_out,
  output logic        item_valid,
  output logic [4:0]  count_out,
  output logic        status
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SDecide = 3'd1;
  localparam logic [2:0] SLink = 3'd2;
  localparam logic [2:0] SSweep = 3'd3;
  localparam logic [2:0] SDone = 3'd4;

  localparam int PW = dll_pkg::PtrW;
  localparam int NW = dll_pkg::NodeW;
  localparam int CW = dll_pkg::CntW;
  localparam int OW = dll_pkg::OwnW;
  localparam int IW = dll_pkg::ItemWidth;

  // Link write micro-op: set next or prev of one entry.
  typedef struct packed {
    logic     is_prev;
    dll_pkg::ptr_t ent;
    dll_pkg::ptr_t val;
  } lop_t;

  logic [PW-1:0] next_ptr [dll_pkg::Entries];
  logic [PW-1:0] prev_ptr [dll_pkg::Entries];
  logic [OW-1:0] owner_list [dll_pkg::NodeCount];
  logic [IW-1:0] node_item [dll_pkg::NodeCount];
  logic [CW-1:0] member_count [dll_pkg::ListCount];

  logic [2:0] state;
  logic [3:0] req;
  logic [1:0] lid;
  logic [NW-1:0] nid;
  logic [NW-1:0] rid;
  logic [IW-1:0] val;
  lop_t ops [8];
  logic [2:0] op_idx;
  logic [2:0] op_cnt;
  logic [NW-1:0] sweep;
  logic res_valid;
  logic res_status;
  logic [1:0] res_list;
  logic res_lok;
  logic [NW-1:0] item_node;

  function automatic dll_pkg::ptr_t clampp(input dll_pkg::ptr_t p);
    clampp = (int'(p) < dll_pkg::Entries) ? p : '0;
  endfunction

  function automatic dll_pkg::ptr_t npt(input logic [NW-1:0] n);
    npt = PW'(n);
  endfunction

  assign in_ready = (state == SIdle) && (!out_valid || out_ready);

  // Decision-cycle combinational plan.
  dll_pkg::ptr_t s, h, h2, p, q, b;
  logic own_n, own_r;
  lop_t plan [8];
  logic [2:0] plan_cnt;
  always_comb begin
    s = PW'(dll_pkg::NodeCount) + PW'(lid);
    h = clampp(next_ptr[s]);
    h2 = clampp(next_ptr[h]);
    own_n = owner_list[nid] != '0;
    own_r = owner_list[rid] != '0;
    p = clampp(prev_ptr[npt(nid)]);
    q = clampp(next_ptr[npt(nid)]);
    b = '0;
    plan_cnt = '0;
    for (int i = 0; i < 8; i++) plan[i] = '0;
    unique case (req)
      dll_pkg::ReqBind: begin
        if (own_n) begin
          plan[0] = '{1'b0, p, q};
          plan[1] = '{1'b1, q, p};
          plan_cnt = 3'd2;
        end
      end
      dll_pkg::ReqTail, dll_pkg::ReqHead, dll_pkg::ReqInsert: begin
        if (req == dll_pkg::ReqTail) b = s;
        else if (req == dll_pkg::ReqHead) b = h;
        else b = npt(rid);
        p = clampp(prev_ptr[clampp(b)]);
        plan[0] = '{1'b0, npt(nid), b};
        plan[1] = '{1'b1, npt(nid), p};
        plan[2] = '{1'b0, p, npt(nid)};
        plan[3] = '{1'b1, clampp(b), npt(nid)};
        plan_cnt = 3'd4;
      end
      dll_pkg::ReqGet: begin
        p = clampp(prev_ptr[h]);
        plan[0] = '{1'b0, p, h2};
        plan[1] = '{1'b1, h2, p};
        plan_cnt = 3'd2;
      end
      dll_pkg::ReqRotate: begin
        // Unlink head, then splice before sentinel; prev of sentinel may change by
        // the unlink, so compute it on the post-unlink view.
        p = clampp(prev_ptr[h]);
        q = (s == h2) ? p : clampp(prev_ptr[s]);
        plan[0] = '{1'b0, p, h2};
        plan[1] = '{1'b1, h2, p};
        plan[2] = '{1'b0, h, s};
        plan[3] = '{1'b1, h, q};
        plan[4] = '{1'b0, q, h};
        plan[5] = '{1'b1, s, h};
        plan_cnt = 3'd6;
      end
      dll_pkg::ReqRemove: begin
        plan[0] = '{1'b0, p, q};
        plan[1] = '{1'b1, q, p};
        plan_cnt = 3'd2;
      end
      default: plan_cnt = '0;
    endcase
  end

  // Does the request proceed?
  logic go;
  always_comb begin
    unique case (req)
      dll_pkg::ReqClear: go = 1'b1;
      dll_pkg::ReqBind: go = 1'b1;
      dll_pkg::ReqTail, dll_pkg::ReqHead: go = !own_n;
      dll_pkg::ReqGet, dll_pkg::ReqPeek: go = member_count[lid] != '0;
      dll_pkg::ReqRotate: go = member_count[lid] != '0;
      dll_pkg::ReqInsert: go = own_r && !own_n;
      dll_pkg::ReqRemove, dll_pkg::ReqPrev, dll_pkg::ReqNext: go = own_n;
      default: go = 1'b0;
    endcase
  end

  // Which node supplies the item, which list is reported, and how many link
  // writes follow.
  logic dec_valid;
  logic [NW-1:0] dec_node;
  logic [1:0] dec_list;
  logic [2:0] dec_cnt;
  always_comb begin
    dec_valid = 1'b0;
    dec_node = '0;
    dec_list = lid;
    dec_cnt = go ? plan_cnt : '0;
    if (go) begin
      unique case (req)
        dll_pkg::ReqGet, dll_pkg::ReqPeek: begin
          dec_node = h[NW-1:0];
          dec_valid = int'(h) < dll_pkg::NodeCount;
        end
        dll_pkg::ReqRotate: begin
          // A single member stays where it is.
          if (member_count[lid] == CW'(1)) begin
            dec_node = h[NW-1:0];
            dec_valid = int'(h) < dll_pkg::NodeCount;
            dec_cnt = '0;
          end else begin
            dec_node = h2[NW-1:0];
            dec_valid = int'(h2) < dll_pkg::NodeCount;
          end
        end
        dll_pkg::ReqInsert: begin
          dec_node = nid;
          dec_valid = 1'b1;
          dec_list = owner_list[rid][1:0] - 2'd1;
        end
        dll_pkg::ReqRemove: begin
          dec_node = nid;
          dec_valid = 1'b1;
          dec_list = owner_list[nid][1:0] - 2'd1;
        end
        dll_pkg::ReqPrev: begin
          dec_node = p[NW-1:0];
          dec_valid = int'(p) < dll_pkg::NodeCount;
        end
        dll_pkg::ReqNext: begin
          dec_node = q[NW-1:0];
          dec_valid = int'(q) < dll_pkg::NodeCount;
        end
        default: ;
      endcase
    end
  end

  lop_t cur;
  assign cur = ops[op_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      out_valid <= 1'b0;
      for (int i = 0; i < dll_pkg::Entries; i++) begin
        next_ptr[i] <= (i >= dll_pkg::NodeCount) ? PW'(i) : '0;
        prev_ptr[i] <= (i >= dll_pkg::NodeCount) ? PW'(i) : '0;
      end
      for (int i = 0; i < dll_pkg::NodeCount; i++) begin
        owner_list[i] <= '0;
        node_item[i] <= '0;
      end
      for (int i = 0; i < dll_pkg::ListCount; i++) member_count[i] <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        SIdle: begin
          if (in_valid && in_ready) begin
            req <= req_type;
            lid <= list_id;
            nid <= node_id;
            rid <= ref_node;
            val <= item_value;
            state <= SDecide;
          end
        end
        SDecide: begin
          res_valid <= dec_valid;
          res_status <= !go;
          res_list <= dec_list;
          res_lok <= 1'b1;
          for (int i = 0; i < 8; i++) ops[i] <= plan[i];
          op_cnt <= dec_cnt;
          op_idx <= '0;
          sweep <= '0;
          item_node <= dec_node;
          if (go) begin
            unique case (req)
              dll_pkg::ReqClear: begin
                next_ptr[s] <= s;
                prev_ptr[s] <= s;
                member_count[lid] <= '0;
              end
              dll_pkg::ReqBind: begin
                if (own_n) begin
                  member_count[owner_list[nid][1:0] - 2'd1] <=
                    member_count[owner_list[nid][1:0] - 2'd1] - CW'(1);
                end
                owner_list[nid] <= '0;
                node_item[nid] <= val;
              end
              dll_pkg::ReqTail, dll_pkg::ReqHead: begin
                owner_list[nid] <= OW'(lid) + OW'(1);
                member_count[lid] <= member_count[lid] + CW'(1);
              end
              dll_pkg::ReqGet: begin
                owner_list[h[NW-1:0]] <= '0;
                member_count[lid] <= member_count[lid] - CW'(1);
              end
              dll_pkg::ReqInsert: begin
                owner_list[nid] <= owner_list[rid];
                member_count[owner_list[rid][1:0] - 2'd1] <=
                  member_count[owner_list[rid][1:0] - 2'd1] + CW'(1);
              end
              dll_pkg::ReqRemove: begin
                owner_list[nid] <= '0;
                member_count[owner_list[nid][1:0] - 2'd1] <=
                  member_count[owner_list[nid][1:0] - 2'd1] - CW'(1);
              end
              default: ;
            endcase
            state <= (req == dll_pkg::ReqClear) ? SSweep : SLink;
          end else begin
            state <= SDone;
          end
        end
        SLink: begin
          // Shared link unit: one pointer write per cycle.
          if (op_idx == op_cnt) begin
            if (req == dll_pkg::ReqBind) begin
              next_ptr[npt(nid)] <= '0;
              prev_ptr[npt(nid)] <= '0;
            end
            state <= SDone;
          end else begin
            if (cur.is_prev) prev_ptr[clampp(cur.ent)] <= cur.val;
            else next_ptr[clampp(cur.ent)] <= cur.val;
            op_idx <= op_idx + 3'd1;
          end
        end
        SSweep: begin
          if (owner_list[sweep] == OW'(lid) + OW'(1)) owner_list[sweep] <= '0;
          sweep <= sweep + NW'(1);
          if (sweep == NW'(dll_pkg::NodeCount - 1)) state <= SDone;
        end
        SDone: begin
          if (!out_valid) begin
            item_out <= res_valid ? node_item[item_node] : '0;
            item_valid <= res_valid;
            count_out <= res_lok ? 5'(member_count[res_list]) : '0;
            status <= res_status;
            out_valid <= 1'b1;
            state <= SIdle;
          end
        end
        default: state <= SIdle;
      endcase
    end
  end

  `DLL_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == SIdle)
  `DLL_ASSERT_NXT(a_accept_decide, clk, rst, in_valid && in_ready, state == SDecide)
  `DLL_ASSERT_IMP(a_ops_bound, clk, rst, state == SLink, op_idx <= op_cnt)
  `DLL_ASSERT_NXT(a_done_out, clk, rst, state == SDone && !out_valid, out_valid)
endmodule
